@@ src/qdac_pkg.sv @@
package qdac_pkg;

  localparam int CodeW          = 16;
  localparam int PwrW           = 2;
  localparam int OutCh          = 4;
  localparam int MaskBits       = 4;
  localparam int ChW            = 3;
  localparam int NumChannelsDef = 4;
  localparam int CodeBitsDef    = 16;

  localparam logic [ChW-1:0] ChAll = 3'd4;

  typedef enum logic [2:0] {
    OP_WRITE          = 3'd0,
    OP_WRITE_LOAD     = 3'd1,
    OP_WRITE_LOAD_ALL = 3'd2,
    OP_LOAD           = 3'd3,
    OP_POWER          = 3'd4,
    OP_RESET          = 3'd5,
    OP_AUTO           = 3'd6,
    OP_REF            = 3'd7
  } op_t;

  localparam logic [PwrW-1:0] PwrNormal = 2'd0;

endpackage

@@ src/quad_dac_register_model_top.sv @@
// Register model of a four-channel DAC, one decoded command per beat.
// Input channel (in_valid/in_ready): op, channel, value, power_mode,
// channel_mask, full_reset, ref_on. Channel code 4 addresses all channels.
// Result channel (out_valid/out_ready): DAC codes out_a..out_d, power modes,
// auto-update mask and reference select as they stand after the command.
// Latency: the result is valid in the cycle after the command is taken.
// Throughput: one command per cycle while results are taken; the state
// registers are updated in a single pass of logic from the accepted beat.
// A command is taken whenever no result is pending or the pending result is
// taken in the same cycle, so a stalled receiver holds the result steady and
// stops input only while it stalls.
// Reset (rst_n low, synchronous) zeroes input and DAC registers, powers all
// channels to normal, clears the auto-update mask, selects the external
// reference and drops out_valid.
// Channels at or above NUM_CHANNELS read as zero. For CODE_BITS below 16 the
// low bits of value are dropped and read back as zero.
module quad_dac_register_model_top #(
  parameter int NUM_CHANNELS = qdac_pkg::NumChannelsDef,
  parameter int CODE_BITS    = qdac_pkg::CodeBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_op,
  input  logic [qdac_pkg::ChW-1:0]    in_channel,
  input  logic [qdac_pkg::CodeW-1:0]  in_value,
  input  logic [qdac_pkg::PwrW-1:0]   in_power_mode,
  input  logic [qdac_pkg::MaskBits-1:0] in_channel_mask,
  input  logic                        in_full_reset,
  input  logic                        in_ref_on,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [qdac_pkg::CodeW-1:0]  out_a,
  output logic [qdac_pkg::CodeW-1:0]  out_b,
  output logic [qdac_pkg::CodeW-1:0]  out_c,
  output logic [qdac_pkg::CodeW-1:0]  out_d,
  output logic [qdac_pkg::PwrW-1:0]   out_power_a,
  output logic [qdac_pkg::PwrW-1:0]   out_power_b,
  output logic [qdac_pkg::PwrW-1:0]   out_power_c,
  output logic [qdac_pkg::PwrW-1:0]   out_power_d,
  output logic [qdac_pkg::MaskBits-1:0] out_auto_update,
  output logic                        out_ref_internal
);

  localparam int NumPwr    = (NUM_CHANNELS < qdac_pkg::MaskBits) ?
                             NUM_CHANNELS : qdac_pkg::MaskBits;
  localparam int CodeShift = qdac_pkg::CodeW - CODE_BITS;

  logic [CODE_BITS-1:0]      inreg_r  [NUM_CHANNELS];
  logic [CODE_BITS-1:0]      inreg_nxt[NUM_CHANNELS];
  logic [CODE_BITS-1:0]      dac_r    [NUM_CHANNELS];
  logic [CODE_BITS-1:0]      dac_nxt  [NUM_CHANNELS];
  logic [qdac_pkg::PwrW-1:0] pwr_r    [NumPwr];
  logic [qdac_pkg::PwrW-1:0] pwr_nxt  [NumPwr];
  logic [NumPwr-1:0]         auto_r, auto_nxt;
  logic                      ref_r, ref_nxt;
  logic                      out_valid_r;

  qdac_pkg::op_t             op;
  logic [CODE_BITS-1:0]      code;
  logic                      in_fire;

  logic [qdac_pkg::CodeW-1:0] out_code[qdac_pkg::OutCh];
  logic [qdac_pkg::PwrW-1:0]  out_pwr [qdac_pkg::OutCh];

  assign op       = qdac_pkg::op_t'(in_op);
  assign code     = in_value[qdac_pkg::CodeW-1 -: CODE_BITS];
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    logic hit;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      inreg_nxt[i] = inreg_r[i];
      dac_nxt[i]   = dac_r[i];
    end
    for (int i = 0; i < NumPwr; i++) begin
      pwr_nxt[i] = pwr_r[i];
    end
    auto_nxt = auto_r;
    ref_nxt  = ref_r;
    hit      = 1'b0;
    case (op)
      qdac_pkg::OP_WRITE, qdac_pkg::OP_WRITE_LOAD, qdac_pkg::OP_WRITE_LOAD_ALL: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          hit = (in_channel == qdac_pkg::ChAll) || (in_channel == qdac_pkg::ChW'(i));
          if (hit) begin
            inreg_nxt[i] = code;
            if (op == qdac_pkg::OP_WRITE_LOAD) begin
              dac_nxt[i] = code;
            end
            if (i < NumPwr) begin
              if (auto_r[i % NumPwr]) begin
                dac_nxt[i] = code;
              end
            end
          end
          if (op == qdac_pkg::OP_WRITE_LOAD_ALL) begin
            dac_nxt[i] = inreg_nxt[i];
          end
        end
      end
      qdac_pkg::OP_LOAD: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if ((in_channel == qdac_pkg::ChAll) || (in_channel == qdac_pkg::ChW'(i))) begin
            dac_nxt[i] = inreg_r[i];
          end
        end
      end
      qdac_pkg::OP_POWER: begin
        for (int i = 0; i < NumPwr; i++) begin
          if (in_channel_mask[i]) begin
            pwr_nxt[i] = in_power_mode;
          end
        end
      end
      qdac_pkg::OP_RESET: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          inreg_nxt[i] = '0;
          dac_nxt[i]   = '0;
        end
        if (in_full_reset) begin
          for (int i = 0; i < NumPwr; i++) begin
            pwr_nxt[i] = qdac_pkg::PwrNormal;
          end
          auto_nxt = '0;
          ref_nxt  = 1'b0;
        end
      end
      qdac_pkg::OP_AUTO: begin
        auto_nxt = in_channel_mask[NumPwr-1:0];
      end
      qdac_pkg::OP_REF: begin
        ref_nxt = in_ref_on;
      end
      default: begin
        ref_nxt = ref_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        inreg_r[i] <= '0;
        dac_r[i]   <= '0;
      end
      for (int i = 0; i < NumPwr; i++) begin
        pwr_r[i] <= qdac_pkg::PwrNormal;
      end
      auto_r      <= '0;
      ref_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          inreg_r[i] <= inreg_nxt[i];
          dac_r[i]   <= dac_nxt[i];
        end
        for (int i = 0; i < NumPwr; i++) begin
          pwr_r[i] <= pwr_nxt[i];
        end
        auto_r <= auto_nxt;
        ref_r  <= ref_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < qdac_pkg::OutCh; g++) begin : g_out
    if (g < NUM_CHANNELS) begin : g_code
      assign out_code[g] = qdac_pkg::CodeW'(dac_r[g]) << CodeShift;
    end else begin : g_code_none
      assign out_code[g] = '0;
    end
    if (g < NumPwr) begin : g_pwr
      assign out_pwr[g] = pwr_r[g];
    end else begin : g_pwr_none
      assign out_pwr[g] = qdac_pkg::PwrNormal;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_a            = out_code[0];
  assign out_b            = out_code[1];
  assign out_c            = out_code[2];
  assign out_d            = out_code[3];
  assign out_power_a      = out_pwr[0];
  assign out_power_b      = out_pwr[1];
  assign out_power_c      = out_pwr[2];
  assign out_power_d      = out_pwr[3];
  assign out_auto_update  = qdac_pkg::MaskBits'(auto_r);
  assign out_ref_internal = ref_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid && !out_ready))
    else $error("beat taken while result stalled");

  a_full_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (op == qdac_pkg::OP_RESET) && in_full_reset |=>
      out_valid && (out_auto_update == '0) && !out_ref_internal &&
      (out_a == '0) && (out_b == '0) && (out_c == '0) && (out_d == '0))
    else $error("full reset left state behind");

  a_auto_mask: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (op == qdac_pkg::OP_AUTO) |=>
      out_auto_update == qdac_pkg::MaskBits'($past(in_channel_mask[NumPwr-1:0])))
    else $error("auto-update mask not loaded");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(out_a) && $stable(out_auto_update) && $stable(out_ref_internal))
    else $error("state changed without a beat");

endmodule
